/* design/shetc_pkg.sv */
// ----------------------------------------------------------------------------
// shetc_pkg: shared types and constants
// Field widths, operation codes and payload words of the saturating
// hot-entry counter table.
// ----------------------------------------------------------------------------
package shetc_pkg;

  localparam int COUNT_W = 8;
  localparam int INDEX_W = 12;
  localparam int END_W   = 13;
  localparam int OP_W    = 2;

  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam logic [COUNT_W-1:0] HOT_LIMIT_RESET = 8'd4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD         = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR_RANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 2'd2;
  localparam logic [OP_W-1:0] OP_GROW        = 2'd3;

  // Input word
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] card_index;
    logic [END_W-1:0]   range_end;
  } item_t;

  // Result word
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               hot;
    logic               in_range;
  } result_t;

endpackage

/* design/shetc_ram.sv */
// ----------------------------------------------------------------------------
// shetc_ram: counter storage
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module shetc_ram #(
  parameter int DEPTH = shetc_pkg::TABLE_ENTRIES_DEF,
  parameter int AW    = $clog2(shetc_pkg::TABLE_ENTRIES_DEF),
  parameter int DW    = shetc_pkg::COUNT_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/saturating_hot_entry_counter_table_unit.sv */
// ----------------------------------------------------------------------------
// saturating_hot_entry_counter_table_unit: hot-entry counter table
// Per-entry saturating 8-bit counters over a committed length that only
// grows; add, clear range, clear all and grow commands.
// ----------------------------------------------------------------------------
// An add reads the entry from the counter memory at the accept edge,
// writes it back in the following cycle and strobes its result word on
// done in the cycle after that. Clear range, clear all and grow walk the
// counter memory one entry per cycle through the same address counter and
// comparator. busy is high while a command is at work; start is taken only
// when busy is low, and may be raised again in the cycle done is shown. The
// result word is present for exactly one cycle; the receiver cannot stall
// it. No clearing pass follows reset: grow zeroes every entry before it can
// be read. cfg_ready is always high; write hot_limit only while idle.
// ----------------------------------------------------------------------------
module saturating_hot_entry_counter_table_unit #(
  parameter int TABLE_ENTRIES = shetc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  shetc_pkg::item_t                  item,
  output logic                              done,
  output shetc_pkg::result_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [shetc_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int XW = (CW > shetc_pkg::END_W) ? CW : shetc_pkg::END_W;
  localparam logic [XW-1:0] TABLE_SIZE = XW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_CLEAR
  } state_t;

  state_t                      state;
  logic [CW-1:0]               committed;
  logic [shetc_pkg::COUNT_W-1:0] hot_limit;
  logic [XW-1:0]               ptr;
  logic [XW-1:0]               lim;

  logic                        accept;
  logic                        present;
  logic [XW-1:0]               cmp_b;
  logic                        ptr_lt;
  logic [XW-1:0]               in_idx;
  logic [XW-1:0]               in_end;
  logic [XW-1:0]               comm_x;
  logic [XW-1:0]               clamp_end;
  logic [XW-1:0]               grow_tgt;

  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [shetc_pkg::COUNT_W-1:0] mem_wdata;
  logic [IW-1:0]               mem_raddr;
  logic [shetc_pkg::COUNT_W-1:0] rd_data;
  logic                        below_limit;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign present   = (hot_limit != '0);

  assign in_idx    = XW'(item.card_index);
  assign in_end    = XW'(item.range_end);
  assign comm_x    = XW'(committed);
  assign clamp_end = (in_end < comm_x) ? in_end : comm_x;
  assign grow_tgt  = (in_end < TABLE_SIZE) ? in_end : TABLE_SIZE;

  // Shared compare: entry index against committed length or sweep limit
  assign cmp_b  = (state == S_MOD) ? comm_x : lim;
  assign ptr_lt = (ptr < cmp_b);

  assign below_limit = (rd_data < hot_limit);

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IW'(ptr);
    mem_wdata = '0;
    case (state)
      S_MOD: begin
        mem_we    = present && ptr_lt && below_limit;
        mem_wdata = rd_data + 8'd1;
      end
      S_CLEAR: begin
        mem_we = ptr_lt;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_raddr = IW'(item.card_index);

  shetc_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW),
    .DW    (shetc_pkg::COUNT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Sequencer, table state and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      committed <= '0;
      hot_limit <= shetc_pkg::HOT_LIMIT_RESET;
      done      <= 1'b0;
      result    <= '0;
      ptr       <= '0;
      lim       <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        hot_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.operation)
              shetc_pkg::OP_ADD: begin
                ptr   <= in_idx;
                state <= S_MOD;
              end
              shetc_pkg::OP_CLEAR_RANGE: begin
                ptr   <= in_idx;
                lim   <= present ? clamp_end : '0;
                state <= S_CLEAR;
              end
              shetc_pkg::OP_CLEAR_ALL: begin
                ptr   <= '0;
                lim   <= present ? comm_x : '0;
                state <= S_CLEAR;
              end
              shetc_pkg::OP_GROW: begin
                ptr <= comm_x;
                if (present && (grow_tgt > comm_x)) begin
                  lim       <= grow_tgt;
                  committed <= CW'(grow_tgt);
                end else begin
                  lim <= comm_x;
                end
                state <= S_CLEAR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MOD: begin
          // Report prior count, flag hot at or above the limit; zero word when absent or out of range
          done  <= 1'b1;
          state <= S_IDLE;
          if (present && ptr_lt) begin
            result.count    <= rd_data;
            result.hot      <= !below_limit;
            result.in_range <= 1'b1;
          end else begin
            result <= '0;
          end
        end
        S_CLEAR: begin
          // Advance the sweep, finish when the limit is reached
          if (ptr_lt) begin
            ptr <= ptr + 1'b1;
          end else begin
            done   <= 1'b1;
            result <= '0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_hot_in_range : assert property (@(posedge clk) disable iff (rst)
    (done && result.hot) |-> result.in_range)
    else $error("hot flagged outside committed length");

  a_commit_grows : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (committed >= $past(committed)))
    else $error("committed length shrank");

  a_commit_bound : assert property (@(posedge clk) disable iff (rst)
    (XW'(committed) <= TABLE_SIZE))
    else $error("committed length beyond table size");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command did not raise busy");

endmodule

/* tb/sv/tb_saturating_hot_entry_counter_table_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_saturating_hot_entry_counter_table_unit: self-checking testbench
// Drives add, clear range, clear all and grow commands into the counter
// table, first from a short directed table and then in random bursts under
// several hot limits. A shadow table predicts untyped results, typed rows
// give their own, and all are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_saturating_hot_entry_counter_table_unit;

  localparam int TABLE_ENTRIES = shetc_pkg::TABLE_ENTRIES_DEF;
  localparam int IDLE_LIMIT    = 50000;
  localparam int REPORT_CAP    = 40;

  typedef struct {
    shetc_pkg::item_t   cmd;
    bit                 typed;
    shetc_pkg::result_t want;
  } directed_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  shetc_pkg::item_t              item;
  logic                          done;
  shetc_pkg::result_t            result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [shetc_pkg::COUNT_W-1:0] cfg_data;

  // Shadow of the table state
  bit [shetc_pkg::COUNT_W-1:0] shadow_counts [TABLE_ENTRIES];
  int unsigned                 shadow_committed;
  bit [shetc_pkg::COUNT_W-1:0] shadow_limit;

  shetc_pkg::result_t expected_results [$];
  directed_row_t      directed_rows [$];
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;

  saturating_hot_entry_counter_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Zero committed entries in [from, upto), clamped to the committed length
  function automatic void zero_counts(int unsigned from, int unsigned upto);
    int unsigned stop;
    stop = (upto > shadow_committed) ? shadow_committed : upto;
    for (int unsigned i = from; i < stop; i++) shadow_counts[i] = '0;
  endfunction

  // Apply one command to the shadow table and return its result word
  function automatic shetc_pkg::result_t count_table_step(shetc_pkg::item_t cmd);
    shetc_pkg::result_t r;
    int unsigned        prior;
    int unsigned        target;
    int unsigned        old_len;
    r = '0;
    if (shadow_limit != 0) begin
      case (cmd.operation)
        shetc_pkg::OP_ADD: begin
          if (32'(cmd.card_index) < shadow_committed) begin
            prior      = 32'(shadow_counts[cmd.card_index]);
            r.count    = prior[shetc_pkg::COUNT_W-1:0];
            r.in_range = 1'b1;
            if (prior < 32'(shadow_limit))
              shadow_counts[cmd.card_index] = shetc_pkg::COUNT_W'(prior + 1);
            else r.hot = 1'b1;
          end
        end
        shetc_pkg::OP_CLEAR_RANGE: zero_counts(32'(cmd.card_index), 32'(cmd.range_end));
        shetc_pkg::OP_CLEAR_ALL:   zero_counts(0, shadow_committed);
        shetc_pkg::OP_GROW: begin
          target = (32'(cmd.range_end) > TABLE_ENTRIES) ? TABLE_ENTRIES
                                                        : 32'(cmd.range_end);
          if (target > shadow_committed) begin
            old_len          = shadow_committed;
            shadow_committed = target;
            zero_counts(old_len, target);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic void add_row(logic [shetc_pkg::OP_W-1:0] op, int unsigned idx,
                                  int unsigned upto, bit typed, int unsigned cnt = 0,
                                  bit hot = 0, bit inr = 0);
    directed_row_t row;
    row.cmd.operation  = op;
    row.cmd.card_index = idx[shetc_pkg::INDEX_W-1:0];
    row.cmd.range_end  = upto[shetc_pkg::END_W-1:0];
    row.typed          = typed;
    row.want.count     = cnt[shetc_pkg::COUNT_W-1:0];
    row.want.hot       = hot;
    row.want.in_range  = inr;
    directed_rows.push_back(row);
  endfunction

  // Random command: adds aim at a small pool of entries so counts climb
  function automatic shetc_pkg::item_t random_command(int add_pct, int pool, int grow_cap);
    shetc_pkg::item_t cmd;
    int unsigned      from;
    int unsigned      k;
    int unsigned      top;
    cmd = '0;
    top = (shadow_committed > 0) ? shadow_committed - 1 : 0;
    if ($urandom_range(0, 99) < add_pct) begin
      cmd.operation  = shetc_pkg::OP_ADD;
      cmd.card_index = ($urandom_range(0, 4) == 0)
                       ? shetc_pkg::INDEX_W'($urandom_range(0, 4095))
                       : shetc_pkg::INDEX_W'($urandom_range(0, pool - 1));
      cmd.range_end  = shetc_pkg::END_W'($urandom_range(0, 8191));
    end else begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        from = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, top);
        cmd.operation  = shetc_pkg::OP_CLEAR_RANGE;
        cmd.card_index = shetc_pkg::INDEX_W'(from);
        cmd.range_end  = ($urandom_range(0, 9) == 0)
                         ? shetc_pkg::END_W'($urandom_range(0, 8191))
                         : shetc_pkg::END_W'(from + $urandom_range(0, 12));
      end else if (k == 6) begin
        cmd.operation  = shetc_pkg::OP_CLEAR_ALL;
        cmd.card_index = shetc_pkg::INDEX_W'($urandom_range(0, 4095));
        cmd.range_end  = shetc_pkg::END_W'($urandom_range(0, 8191));
      end else begin
        cmd.operation  = shetc_pkg::OP_GROW;
        cmd.card_index = shetc_pkg::INDEX_W'($urandom_range(0, 4095));
        cmd.range_end  = shetc_pkg::END_W'($urandom_range(0, grow_cap));
      end
    end
    return cmd;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  // Hold start and the word until taken, then log the expected result
  task automatic issue_command(input shetc_pkg::item_t cmd, input bit typed,
                               input shetc_pkg::result_t want);
    shetc_pkg::result_t predicted;
    start <= 1'b1;
    item  <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = count_table_step(cmd);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Write the hot limit once every result is back and the block is idle
  task automatic write_hot_limit(input bit [shetc_pkg::COUNT_W-1:0] lim);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_limit = lim;
    cfg_valid <= 1'b0;
  endtask

  // Set the hot limit, then random commands in bursts with gaps; now and then drain all results
  task automatic run_phase(input bit [shetc_pkg::COUNT_W-1:0] lim, input int items,
                           input int add_pct, input int pool, input int grow_cap);
    int                 burst;
    shetc_pkg::result_t none;
    none = '0;
    write_hot_limit(lim);
    burst = $urandom_range(1, 24);
    for (int n = 0; n < items; n++) begin
      issue_command(random_command(add_pct, pool, grow_cap), 1'b0, none);
      burst--;
      if (burst == 0 || n == items - 1) begin
        start <= 1'b0;
        if ($urandom_range(0, 19) == 0) begin
          @(posedge clk);
          while (expected_results.size() != 0) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      end
    end
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin : result_check
    shetc_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: no result expected, actual count %0d hot %0d in_range %0d",
                   $time, result.count, result.hot, result.in_range);
      end else begin
        want = expected_results.pop_front();
        check_field("count", 32'(want.count), 32'(result.count));
        check_field("hot", 32'(want.hot), 32'(result.hot));
        check_field("in_range", 32'(want.in_range), 32'(result.in_range));
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    shadow_committed = 0;
    shadow_limit     = shetc_pkg::HOT_LIMIT_RESET;

    // Directed commands at the reset hot limit
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 0, 0, 0);  // nothing committed yet
    add_row(shetc_pkg::OP_GROW,        0,    0,    1);
    add_row(shetc_pkg::OP_GROW,        0,    16,   1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 0, 0, 1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 1, 0, 1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 2, 0, 1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 3, 0, 1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 4, 1, 1);  // reaches the limit
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 4, 1, 1);  // stays saturated
    add_row(shetc_pkg::OP_ADD,         15,   0,    1, 0, 0, 1);
    add_row(shetc_pkg::OP_ADD,         16,   0,    1, 0, 0, 0);  // just past committed length
    add_row(shetc_pkg::OP_ADD,         4095, 8191, 1, 0, 0, 0);
    add_row(shetc_pkg::OP_CLEAR_RANGE, 0,    1,    1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 0, 0, 1);
    add_row(shetc_pkg::OP_CLEAR_RANGE, 5,    3,    0);           // start past end
    add_row(shetc_pkg::OP_ADD,         15,   0,    1, 1, 0, 1);
    add_row(shetc_pkg::OP_CLEAR_RANGE, 10,   8191, 1);           // end clamped
    add_row(shetc_pkg::OP_ADD,         15,   0,    1, 0, 0, 1);
    add_row(shetc_pkg::OP_CLEAR_ALL,   0,    0,    1);
    add_row(shetc_pkg::OP_ADD,         0,    0,    1, 0, 0, 1);
    add_row(shetc_pkg::OP_GROW,        0,    8,    1);           // not above committed length
    add_row(shetc_pkg::OP_ADD,         0,    0,    0);
    add_row(shetc_pkg::OP_CLEAR_RANGE, 4095, 4096, 0);
    add_row(shetc_pkg::OP_ADD,         3,    4096, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      issue_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    start <= 1'b0;

    run_phase(8'd4,   150, 70, 6, 48);
    run_phase(8'd255, 300, 95, 1, 48);    // build counts up on one entry
    run_phase(8'd4,    60, 90, 2, 48);    // counts now above the lowered limit
    run_phase(8'd0,    60, 60, 6, 8191);  // table absent
    run_phase(8'd1,   120, 70, 4, 200);
    run_phase(8'd2,   100, 70, 3, 200);
    run_phase(8'd7,   120, 65, 8, 8191);  // grow to the full table

    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
